>>> rtl/ged_pkg.sv
// Shared types and constants for the gray error diffusion ditherer.
// Depends on nothing; the top level, front end and back end refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package ged_pkg;

    localparam int LINE_MAX_DEFAULT    = 1024;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam int LEN_W       = 11;
    localparam int CNT_W       = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_LINE_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LINE_COUNT  = 2'd1;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic white;
        logic image_end;
    } result_t;

    typedef struct packed {
        logic [7:0] gray;
        logic       line_end;
        logic       image_end;
        logic       later_line;
    } item_t;

endpackage

`default_nettype wire

>>> rtl/gray_error_diffusion_dither.sv
// Top level of the gray error diffusion ditherer.
// Depends on ged_pkg, ged_front, ged_queue and ged_back.
//
// Takes one RGB pixel word per clock in scan order and returns one word per
// pixel: white or black, plus a flag on the last pixel of the image. Sustained
// rate is one pixel per cycle while result_ready stays high; result valid follows
// the pixel accept edge, which loads the product register, through the queue,
// the line store read and the output register.
// The line store is a LINE_MAX x 14 RAM with one write and one registered read
// port, read and written once per pixel; it needs no clearing pass, since the
// first line of every image ignores it. Write line_length and line_count only
// while no pixel is in flight.
`timescale 1ns / 1ps
`default_nettype none

module gray_error_diffusion_dither #(
    parameter int LINE_MAX    = ged_pkg::LINE_MAX_DEFAULT,
    parameter int QUEUE_DEPTH = ged_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             pixel_valid,
    output logic                                  pixel_ready,
    input  wire ged_pkg::pixel_t                  pixel,
    output logic                                  result_valid,
    input  wire logic                             result_ready,
    output ged_pkg::result_t                      result,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [ged_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [ged_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int AW = $clog2(LINE_MAX);
    localparam int QW = $bits(ged_pkg::item_t) + AW;

    logic           front_valid;
    logic           front_ready;
    ged_pkg::item_t front_item;
    logic [AW-1:0]  front_pos;
    logic           back_valid;
    logic           back_ready;
    ged_pkg::item_t back_item;
    logic [AW-1:0]  back_pos;
    logic [QW-1:0]  queue_out;

    ged_front #(
        .LINE_MAX (LINE_MAX)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel       (pixel),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .item_valid  (front_valid),
        .item_ready  (front_ready),
        .item        (front_item),
        .item_pos    (front_pos)
    );

    ged_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   ({front_pos, front_item}),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_data  (queue_out)
    );

    assign back_item = queue_out[$bits(ged_pkg::item_t)-1:0];
    assign back_pos  = queue_out[QW-1:$bits(ged_pkg::item_t)];

    ged_back #(
        .LINE_MAX (LINE_MAX)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (back_valid),
        .item_ready   (back_ready),
        .item         (back_item),
        .item_pos     (back_pos),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire

>>> rtl/ged_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module ged_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/ged_front.sv
// Front end: configuration registers, pixel intake, gray products and scan position.
// Depends on ged_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ged_front #(
    parameter int LINE_MAX = ged_pkg::LINE_MAX_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               pixel_valid,
    output logic                                    pixel_ready,
    input  wire ged_pkg::pixel_t                    pixel,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [ged_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [ged_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                    item_valid,
    input  wire logic                               item_ready,
    output ged_pkg::item_t                          item,
    output logic      [$clog2(LINE_MAX)-1:0]        item_pos
);

    localparam int AW = $clog2(LINE_MAX);
    localparam int CW = (AW + 1 > ged_pkg::LEN_W) ? AW + 1 : ged_pkg::LEN_W;
    localparam int PW = 24;
    localparam logic [PW-1:0] COEF_R = 24'd19595;
    localparam logic [PW-1:0] COEF_G = 24'd38470;
    localparam logic [PW-1:0] COEF_B = 24'd7471;
    localparam logic [PW-1:0] ROUND  = 24'd32768;

    logic [ged_pkg::LEN_W-1:0] line_length_reg;
    logic [ged_pkg::CNT_W-1:0] line_count_reg;
    logic [AW-1:0]             pos_reg;
    logic [AW-1:0]             pos_next;
    logic [ged_pkg::CNT_W-1:0] line_reg;
    logic [ged_pkg::CNT_W-1:0] line_next;

    logic                      f_valid_reg;
    logic [PW-1:0]             prod_r_reg;
    logic [PW-1:0]             prod_g_reg;
    logic [PW-1:0]             prod_b_reg;
    logic [AW-1:0]             f_pos_reg;
    logic                      f_line_end_reg;
    logic                      f_image_end_reg;
    logic                      f_later_reg;

    logic                      accept;
    logic [CW-1:0]             len_raw;
    logic [CW-1:0]             len_eff;
    logic [ged_pkg::CNT_W-1:0] cnt_eff;
    logic                      line_end;
    logic                      image_end;
    logic [PW-1:0]             gray_sum;

    assign cfg_ready   = 1'b1;
    assign pixel_ready = !f_valid_reg || item_ready;
    assign accept      = pixel_valid && pixel_ready;

    always_comb
    begin
        len_raw = CW'(line_length_reg);
        if (len_raw == '0)
        begin
            len_eff = CW'(1);
        end
        else if (len_raw > CW'(LINE_MAX))
        begin
            len_eff = CW'(LINE_MAX);
        end
        else
        begin
            len_eff = len_raw;
        end
        cnt_eff   = (line_count_reg == '0) ? ged_pkg::CNT_W'(1) : line_count_reg;
        line_end  = (CW'(pos_reg) + CW'(1)) >= len_eff;
        image_end = line_end
                    && (({1'b0, line_reg} + 17'd1) >= {1'b0, cnt_eff});
        pos_next  = line_end ? '0 : pos_reg + AW'(1);
        if (image_end)
        begin
            line_next = '0;
        end
        else if (line_end)
        begin
            line_next = line_reg + ged_pkg::CNT_W'(1);
        end
        else
        begin
            line_next = line_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_length_reg <= ged_pkg::LEN_W'(1024);
            line_count_reg  <= ged_pkg::CNT_W'(1);
            pos_reg         <= '0;
            line_reg        <= '0;
            f_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    ged_pkg::REG_LINE_LENGTH: line_length_reg <= cfg_data[ged_pkg::LEN_W-1:0];
                    ged_pkg::REG_LINE_COUNT:  line_count_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (accept)
            begin
                pos_reg     <= pos_next;
                line_reg    <= line_next;
                f_valid_reg <= 1'b1;
            end
            else if (item_ready)
            begin
                f_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prod_r_reg      <= PW'(pixel.red) * COEF_R;
            prod_g_reg      <= PW'(pixel.green) * COEF_G;
            prod_b_reg      <= PW'(pixel.blue) * COEF_B;
            f_pos_reg       <= pos_reg;
            f_line_end_reg  <= line_end;
            f_image_end_reg <= image_end;
            f_later_reg     <= line_reg != '0;
        end
    end

    assign gray_sum        = prod_r_reg + prod_g_reg + prod_b_reg + ROUND;
    assign item_valid      = f_valid_reg;
    assign item.gray       = gray_sum[PW-1:16];
    assign item.line_end   = f_line_end_reg;
    assign item.image_end  = f_image_end_reg;
    assign item.later_line = f_later_reg;
    assign item_pos        = f_pos_reg;

endmodule

`default_nettype wire

>>> rtl/ged_queue.sv
// Short word queue between the front end and the back end.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module ged_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic      [WIDTH-1:0] out_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign in_ready  = count_reg != CNT_W'(DEPTH);
    assign out_valid = count_reg != '0;
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/ged_back.sv
// Back end: line store access, share accumulation, threshold and output register.
// Depends on ged_pkg and ged_ram.
`timescale 1ns / 1ps
`default_nettype none

module ged_back #(
    parameter int LINE_MAX = ged_pkg::LINE_MAX_DEFAULT
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         item_valid,
    output logic                              item_ready,
    input  wire ged_pkg::item_t               item,
    input  wire logic [$clog2(LINE_MAX)-1:0]  item_pos,
    output logic                              result_valid,
    input  wire logic                         result_ready,
    output ged_pkg::result_t                  result
);

    localparam int AW      = $clog2(LINE_MAX);
    localparam int SHARE_W = 7;
    localparam int WORD_W  = 2 * SHARE_W;

    function automatic logic [7:0] clamp_add(input logic [7:0] v,
                                             input logic signed [SHARE_W-1:0] s);
        logic signed [9:0] t;
        t = $signed({2'b00, v}) + 10'(s);
        if (t < 10'sd0)
        begin
            return 8'd0;
        end
        else if (t > 10'sd255)
        begin
            return 8'd255;
        end
        return t[7:0];
    endfunction

    logic                       r_valid_reg;
    ged_pkg::item_t             r_item_reg;
    logic [AW-1:0]              r_pos_reg;
    logic                       fwd_hit_reg;
    logic [WORD_W-1:0]          fwd_word_reg;
    logic signed [SHARE_W-1:0]  left_reg;
    logic signed [SHARE_W-1:0]  diag_reg;
    logic                       out_valid_reg;
    ged_pkg::result_t           out_reg;

    logic                       fire;
    logic                       load;
    logic [WORD_W-1:0]          ram_word;
    logic [WORD_W-1:0]          word;
    logic [WORD_W-1:0]          word_wr;
    logic signed [SHARE_W-1:0]  upper;
    logic signed [SHARE_W-1:0]  diag_next;
    logic [7:0]                 v_diag;
    logic [7:0]                 v_upper;
    logic [7:0]                 v_left;
    logic                       white;
    logic signed [8:0]          err;
    logic signed [10:0]         err_x;
    logic signed [10:0]         t38;
    logic signed [10:0]         t14;
    logic signed [SHARE_W-1:0]  s38;
    logic signed [SHARE_W-1:0]  s14;

    assign fire       = r_valid_reg && (!out_valid_reg || result_ready);
    assign item_ready = !r_valid_reg || fire;
    assign load       = item_valid && item_ready;

    ged_ram #(
        .WIDTH (WORD_W),
        .DEPTH (LINE_MAX)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (fire),
        .wr_addr (r_pos_reg),
        .wr_data (word_wr),
        .rd_en   (load),
        .rd_addr (item_pos),
        .rd_data (ram_word)
    );

    always_comb
    begin
        word      = fwd_hit_reg ? fwd_word_reg : ram_word;
        upper     = $signed(word[SHARE_W-1:0]);
        diag_next = $signed(word[WORD_W-1:SHARE_W]);
        if (r_item_reg.later_line)
        begin
            v_diag  = clamp_add(r_item_reg.gray, diag_reg);
            v_upper = clamp_add(v_diag, upper);
        end
        else
        begin
            v_diag  = r_item_reg.gray;
            v_upper = r_item_reg.gray;
        end
        v_left = clamp_add(v_upper, left_reg);
        white  = v_left[7];
        err    = white ? ($signed({1'b0, v_left}) - 9'sd255) : $signed({1'b0, v_left});
        err_x  = 11'(err);
        t38    = (err_x <<< 1) + err_x + 11'sd4;
        t14    = err_x + 11'sd2;
        s38    = SHARE_W'(t38 >>> 3);
        s14    = SHARE_W'(t14 >>> 2);
        word_wr = {s14, s38};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_valid_reg   <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            left_reg      <= '0;
            diag_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                r_valid_reg <= 1'b1;
                fwd_hit_reg <= fire && (item_pos == r_pos_reg);
            end
            else if (fire)
            begin
                r_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                if (r_item_reg.line_end)
                begin
                    left_reg <= '0;
                    diag_reg <= '0;
                end
                else
                begin
                    left_reg <= s38;
                    diag_reg <= r_item_reg.later_line ? diag_next : '0;
                end
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            r_item_reg   <= item;
            r_pos_reg    <= item_pos;
            fwd_word_reg <= word_wr;
        end
        if (fire)
        begin
            out_reg.white     <= white;
            out_reg.image_end <= r_item_reg.image_end;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire
